// ===== rtl/core/okle_pkg.sv =====
`default_nettype none
package okle_pkg;

  typedef enum logic [2:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_ORD  = 3'd1,
    REQ_INS_TAIL = 3'd2,
    REQ_RM_HEAD  = 3'd3,
    REQ_RM_TAIL  = 3'd4,
    REQ_RM_KEY   = 3'd5,
    REQ_FIND     = 3'd6,
    REQ_READ     = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/ordered_key_list_engine.sv =====
// Ordered key list engine: keeps up to DEPTH signed keys in list order in a
// single-port-read, single-port-write key memory.
// Input channel (in_*): one request per transfer. in_tuser carries the
// request code; in_tdata carries the key and the one-based position.
// Result channel (out_*): exactly one result per request, in request order:
// status in out_tuser, result key, result position and entry count in
// out_tdata.
// Full, empty and bad-position requests answer without touching the memory;
// insert at tail or into an empty list writes only the new key, and read
// and remove tail read one entry. Insert at head shifts every entry up;
// ordered insert scans for the first larger key, then shifts up from it.
// Find scans from the head; remove key scans from the second entry and the
// head last; removes shift the entries behind the match down.
// Scan and shift share the one read port; only the scan uses the key
// comparator. The slowest request removes the head of a full list by key.
// in_tready is high only while the sequencer is idle.
// Reset empties the list at once; the memory itself is not cleared.
// A result waits in the output register while out_tready is low; the next
// request may be taken meanwhile, and its result holds in the sequencer.
`default_nettype none
module ordered_key_list_engine #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW       = $clog2(DEPTH + 1),
  localparam int IN_DW    = ((KEY_WIDTH + CW + 7) / 8) * 8,
  localparam int OUT_DW   = ((KEY_WIDTH + 2 * CW + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // key, position
  input  wire logic [2:0]        in_tuser,   // req_type
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_DW-1:0] out_tdata,  // result_key, result_position, entry_count
  output logic      [2:0]        out_tuser   // status
);

  logic                 res_valid;
  logic                 res_ready;
  okle_pkg::status_t    res_status;
  logic [KEY_WIDTH-1:0] res_key;
  logic [CW-1:0]        res_pos;
  logic [CW-1:0]        res_count;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [KEY_WIDTH-1:0] out_key_r;
  logic [CW-1:0]        out_pos_r;
  logic [CW-1:0]        out_cnt_r;

  okle_seq #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_type   (okle_pkg::req_t'(in_tuser)),
    .req_key    (in_tdata[KEY_WIDTH-1:0]),
    .req_pos    (in_tdata[KEY_WIDTH +: CW]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_key    (res_key),
    .res_pos    (res_pos),
    .res_count  (res_count),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  okle_store #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res_status;
      out_key_r    <= res_key;
      out_pos_r    <= res_pos;
      out_cnt_r    <= res_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DW'({out_cnt_r, out_pos_r, out_key_r});

endmodule
`default_nettype wire

// ===== rtl/core/okle_cmp.sv =====
`default_nettype none
module okle_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  wire logic signed [KEY_WIDTH-1:0] a,
  input  wire logic signed [KEY_WIDTH-1:0] b,
  output logic                             eq,
  output logic                             lt
);

  assign eq = (a == b);
  assign lt = (a < b);

endmodule
`default_nettype wire

// ===== rtl/core/okle_store.sv =====
`default_nettype none
module okle_store #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [KEY_WIDTH-1:0] rd_data,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [KEY_WIDTH-1:0] wr_data
);

  logic [KEY_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/okle_seq.sv =====
`default_nettype none
module okle_seq #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW       = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire okle_pkg::req_t              req_type,
  input  wire logic        [KEY_WIDTH-1:0] req_key,
  input  wire logic        [CW-1:0]        req_pos,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output okle_pkg::status_t                res_status,
  output logic             [KEY_WIDTH-1:0] res_key,
  output logic             [CW-1:0]        res_pos,
  output logic             [CW-1:0]        res_count,
  output logic                             rd_en,
  output logic             [AW-1:0]        rd_addr,
  input  wire logic        [KEY_WIDTH-1:0] rd_data,
  output logic                             wr_en,
  output logic             [AW-1:0]        wr_addr,
  output logic             [KEY_WIDTH-1:0] wr_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_UP   = 6'b000100,
    S_DOWN = 6'b001000,
    S_PUT  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              iss_on_r, iss_on_nxt;
  logic              rdv_r, rdv_nxt;
  okle_pkg::req_t    req_r, req_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     iss_ptr_r, iss_ptr_nxt;
  logic [AW-1:0]     rda_r, rda_nxt;
  logic [AW-1:0]     term_r, term_nxt;
  okle_pkg::status_t status_r, status_nxt;
  logic [KEY_WIDTH-1:0] rkey_r, rkey_nxt;
  logic [CW-1:0]     rpos_r, rpos_nxt;

  logic [CW-1:0] cnt_dec;
  logic [AW-1:0] cnt_m1;
  logic [CW-1:0] rda_inc;
  logic          eq;
  logic          lt;
  logic          hit;
  logic          last;

  assign cnt_dec = cnt_r - CW'(1);
  assign cnt_m1  = cnt_dec[AW-1:0];
  assign rda_inc = CW'(rda_r) + CW'(1);

  okle_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (
    .a  (key_r),
    .b  (rd_data),
    .eq (eq),
    .lt (lt)
  );

  always_comb begin
    if (req_r inside {okle_pkg::REQ_RM_HEAD, okle_pkg::REQ_RM_TAIL, okle_pkg::REQ_READ}) begin
      hit = 1'b1;
    end else if (req_r == okle_pkg::REQ_INS_ORD) begin
      hit = lt;
    end else begin
      hit = eq;
    end
    last = (rda_r == term_r);
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    iss_on_nxt  = iss_on_r;
    rdv_nxt     = 1'b0;
    req_nxt     = req_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    iss_ptr_nxt = iss_ptr_r;
    rda_nxt     = iss_ptr_r;
    term_nxt    = term_r;
    status_nxt  = status_r;
    rkey_nxt    = rkey_r;
    rpos_nxt    = rpos_r;
    rd_en       = 1'b0;
    rd_addr     = iss_ptr_r;
    wr_en       = 1'b0;
    wr_addr     = rda_r;
    wr_data     = rd_data;
    req_ready   = 1'b0;
    res_valid   = 1'b0;

    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt    = req_type;
          key_nxt    = req_key;
          status_nxt = okle_pkg::ST_OK;
          rkey_nxt   = '0;
          rpos_nxt   = '0;
          iss_ptr_nxt = '0;
          term_nxt    = cnt_m1;
          iss_on_nxt  = 1'b1;
          state_nxt   = S_SCAN;
          if (req_type inside {okle_pkg::REQ_INS_HEAD, okle_pkg::REQ_INS_ORD,
                               okle_pkg::REQ_INS_TAIL}) begin
            if (cnt_r == CW'(DEPTH)) begin
              status_nxt = okle_pkg::ST_FULL;
              iss_on_nxt = 1'b0;
              state_nxt  = S_DONE;
            end else if (req_type == okle_pkg::REQ_INS_HEAD) begin
              idx_nxt     = '0;
              iss_ptr_nxt = cnt_m1;
              iss_on_nxt  = (cnt_r != '0);
              state_nxt   = S_UP;
            end else if (req_type == okle_pkg::REQ_INS_TAIL || cnt_r == '0) begin
              idx_nxt    = cnt_r;
              iss_on_nxt = 1'b0;
              state_nxt  = S_UP;
            end
          end else if (cnt_r == '0) begin
            status_nxt = okle_pkg::ST_EMPTY;
            iss_on_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            case (req_type)
              okle_pkg::REQ_RM_KEY: begin
                iss_ptr_nxt = (cnt_r > CW'(1)) ? AW'(1) : '0;
                term_nxt    = '0;
              end
              okle_pkg::REQ_RM_TAIL: begin
                iss_ptr_nxt = cnt_m1;
                term_nxt    = cnt_m1;
              end
              okle_pkg::REQ_READ: begin
                if (req_pos == '0 || req_pos > cnt_r) begin
                  status_nxt = okle_pkg::ST_RANGE;
                  iss_on_nxt = 1'b0;
                  state_nxt  = S_DONE;
                end
                iss_ptr_nxt = req_pos[AW-1:0] - AW'(1);
                term_nxt    = req_pos[AW-1:0] - AW'(1);
              end
              okle_pkg::REQ_RM_HEAD: begin
                term_nxt = '0;
              end
              default: begin
                term_nxt = cnt_m1;
              end
            endcase
          end
        end
      end

      S_SCAN: begin
        if (iss_on_r) begin
          rd_en   = 1'b1;
          rdv_nxt = 1'b1;
          if (iss_ptr_r == term_r) begin
            iss_on_nxt = 1'b0;
          end else if (req_r == okle_pkg::REQ_RM_KEY && iss_ptr_r == cnt_m1) begin
            iss_ptr_nxt = '0;
          end else begin
            iss_ptr_nxt = iss_ptr_r + AW'(1);
          end
        end
        if (rdv_r && (hit || last)) begin
          rdv_nxt = 1'b0;
          case (req_r)
            okle_pkg::REQ_INS_ORD: begin
              idx_nxt     = hit ? CW'(rda_r) : cnt_r;
              iss_ptr_nxt = cnt_m1;
              iss_on_nxt  = hit;
              state_nxt   = S_UP;
            end
            okle_pkg::REQ_RM_HEAD, okle_pkg::REQ_RM_KEY: begin
              if (hit) begin
                rkey_nxt    = rd_data;
                rpos_nxt    = rda_inc;
                iss_ptr_nxt = rda_r + AW'(1);
                iss_on_nxt  = (rda_inc != cnt_r);
                state_nxt   = S_DOWN;
              end else begin
                status_nxt = okle_pkg::ST_NOT_FOUND;
                iss_on_nxt = 1'b0;
                state_nxt  = S_DONE;
              end
            end
            okle_pkg::REQ_RM_TAIL: begin
              rkey_nxt   = rd_data;
              rpos_nxt   = rda_inc;
              cnt_nxt    = cnt_dec;
              iss_on_nxt = 1'b0;
              state_nxt  = S_DONE;
            end
            okle_pkg::REQ_FIND, okle_pkg::REQ_READ: begin
              if (hit) begin
                rkey_nxt = rd_data;
                rpos_nxt = rda_inc;
              end else begin
                status_nxt = okle_pkg::ST_NOT_FOUND;
              end
              iss_on_nxt = 1'b0;
              state_nxt  = S_DONE;
            end
            default: begin
              iss_on_nxt = 1'b0;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_UP: begin
        if (iss_on_r) begin
          rd_en   = 1'b1;
          rdv_nxt = 1'b1;
          if (iss_ptr_r == idx_r[AW-1:0]) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_ptr_nxt = iss_ptr_r - AW'(1);
          end
        end
        if (rdv_r) begin
          wr_en   = 1'b1;
          wr_addr = rda_r + AW'(1);
        end
        if (!iss_on_r && !rdv_r) begin
          state_nxt = S_PUT;
        end
      end

      S_DOWN: begin
        if (iss_on_r) begin
          rd_en   = 1'b1;
          rdv_nxt = 1'b1;
          if (iss_ptr_r == cnt_m1) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_ptr_nxt = iss_ptr_r + AW'(1);
          end
        end
        if (rdv_r) begin
          wr_en   = 1'b1;
          wr_addr = rda_r - AW'(1);
        end
        if (!iss_on_r && !rdv_r) begin
          cnt_nxt   = cnt_dec;
          state_nxt = S_DONE;
        end
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[AW-1:0];
        wr_data   = key_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      iss_on_r <= 1'b0;
      rdv_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      iss_on_r <= iss_on_nxt;
      rdv_r    <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    iss_ptr_r <= iss_ptr_nxt;
    rda_r     <= rda_nxt;
    term_r    <= term_nxt;
    status_r  <= status_nxt;
    rkey_r    <= rkey_nxt;
    rpos_r    <= rpos_nxt;
  end

  assign res_status = status_r;
  assign res_key    = rkey_r;
  assign res_pos    = rpos_r;
  assign res_count  = cnt_r;

endmodule
`default_nettype wire

// ===== rtl/core/okle_chk.sv =====
`default_nettype none
module okle_chk #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  localparam int CW       = $clog2(DEPTH + 1),
  localparam int OUT_DW   = ((KEY_WIDTH + 2 * CW + 7) / 8) * 8
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic [2:0]        out_tuser
);

  logic [CW-1:0] out_pos;
  logic [CW-1:0] out_cnt;

  assign out_pos = out_tdata[KEY_WIDTH +: CW];
  assign out_cnt = out_tdata[KEY_WIDTH + CW +: CW];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while request in progress");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == okle_pkg::ST_FULL |-> out_cnt == CW'(DEPTH))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == okle_pkg::ST_EMPTY |-> out_cnt == '0)
    else $error("empty status with entries present");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != okle_pkg::ST_OK |->
      out_tdata[KEY_WIDTH-1:0] == '0 && out_pos == '0)
    else $error("failed request carries key or position");

endmodule

bind ordered_key_list_engine okle_chk #(
  .DEPTH     (DEPTH),
  .KEY_WIDTH (KEY_WIDTH)
) u_okle_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 300;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_REQS = 2000;

  typedef struct {
    okle_pkg::req_t     req;
    logic signed [31:0] key;
    logic [6:0]         pos;
    bit                 drain;
  } list_req_t;

  typedef struct {
    okle_pkg::status_t  status;
    logic signed [31:0] key;
    logic [6:0]         pos;
    logic [6:0]         count;
  } list_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;

  list_req_t          request_queue[$];
  list_resp_t         awaited_results[$];
  logic signed [31:0] stored_keys[$];

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  bit   failed = 1'b0;
  int   sent_count = 0;
  int   gap_left = 0;
  int   rcv_count = 0;
  int   stall_left = 0;
  int   cycle_count = 0;

  ordered_key_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic list_resp_t apply_request(okle_pkg::req_t req,
                                               logic signed [31:0] k,
                                               logic [6:0] pos);
    list_resp_t r;
    int n;
    int i;
    int at;
    r = '{status: okle_pkg::ST_OK, key: '0, pos: '0, count: '0};
    n = stored_keys.size();
    at = -1;
    case (req)
      okle_pkg::REQ_INS_HEAD, okle_pkg::REQ_INS_ORD, okle_pkg::REQ_INS_TAIL: begin
        if (n >= DEPTH) begin
          r.status = okle_pkg::ST_FULL;
        end else if (req == okle_pkg::REQ_INS_HEAD) begin
          stored_keys.push_front(k);
        end else if (req == okle_pkg::REQ_INS_TAIL || n == 0) begin
          stored_keys.push_back(k);
        end else if (k < stored_keys[0]) begin
          stored_keys.push_front(k);
        end else begin
          i = 1;
          while (i < n && !(k < stored_keys[i])) i++;
          stored_keys.insert(i, k);
        end
      end
      default: begin
        if (n == 0) begin
          r.status = okle_pkg::ST_EMPTY;
        end else begin
          case (req)
            okle_pkg::REQ_RM_HEAD: begin
              r.key = stored_keys[0];
              r.pos = 7'd1;
              void'(stored_keys.pop_front());
            end
            okle_pkg::REQ_RM_TAIL: begin
              r.key = stored_keys[n-1];
              r.pos = 7'(n);
              void'(stored_keys.pop_back());
            end
            okle_pkg::REQ_RM_KEY: begin
              for (i = 1; i < n; i++)
                if (at < 0 && stored_keys[i] == k) at = i;
              if (at < 0 && stored_keys[0] == k) at = 0;
              if (at < 0) begin
                r.status = okle_pkg::ST_NOT_FOUND;
              end else begin
                r.key = stored_keys[at];
                r.pos = 7'(at + 1);
                stored_keys.delete(at);
              end
            end
            okle_pkg::REQ_FIND: begin
              for (i = 0; i < n; i++)
                if (at < 0 && stored_keys[i] == k) at = i;
              if (at < 0) begin
                r.status = okle_pkg::ST_NOT_FOUND;
              end else begin
                r.key = stored_keys[at];
                r.pos = 7'(at + 1);
              end
            end
            default: begin
              if (pos < 1 || pos > n) begin
                r.status = okle_pkg::ST_RANGE;
              end else begin
                r.key = stored_keys[pos-1];
                r.pos = pos;
              end
            end
          endcase
        end
      end
    endcase
    r.count = 7'(stored_keys.size());
    return r;
  endfunction

  function automatic logic signed [31:0] draw_key();
    logic signed [31:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        k = $urandom_range(0, 15);
        k = k - 8;
      end
      5: begin
        case ($urandom_range(0, 3))
          0: k = 32'h8000_0000;
          1: k = 32'h7fff_ffff;
          2: k = 32'h0000_0000;
          default: k = 32'hffff_ffff;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [6:0] draw_pos();
    if ($urandom_range(0, 1))
      return 7'($urandom_range(1, 8));
    return 7'($urandom_range(0, 64));
  endfunction

  task automatic add_req(okle_pkg::req_t req, logic signed [31:0] k, logic [6:0] pos,
                         bit drain = 1'b0);
    request_queue.push_back('{req: req, key: k, pos: pos, drain: drain});
  endtask

  // transfer on the input side: predict the result
  always @(posedge clk) begin
    in_took <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      awaited_results.push_back(apply_request(okle_pkg::req_t'(in_tuser),
                                              in_tdata[31:0], in_tdata[38:32]));
  end

  // transfer on the result side: compare against the oldest prediction
  always @(posedge clk) begin
    list_resp_t want;
    out_took <= out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d key %0d", out_tuser,
               $signed(out_tdata[31:0]));
        failed = 1'b1;
      end else begin
        want = awaited_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          failed = 1'b1;
        end
        if (out_tdata[31:0] !== want.key) begin
          $error("result_key: expected %0d, got %0d", want.key,
                 $signed(out_tdata[31:0]));
          failed = 1'b1;
        end
        if (out_tdata[38:32] !== want.pos) begin
          $error("result_position: expected %0d, got %0d", want.pos,
                 out_tdata[38:32]);
          failed = 1'b1;
        end
        if (out_tdata[45:39] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count,
                 out_tdata[45:39]);
          failed = 1'b1;
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    list_req_t item;
    if (rst_n) begin
      if (in_took) begin
        sent_count++;
        gap_left = ((sent_count / 100) % 4 == 3) ? 0 : $urandom_range(0, 12);
      end
      if (!in_tvalid || in_took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (request_queue.size() > 0 &&
                     (!request_queue[0].drain || awaited_results.size() == 0)) begin
          item = request_queue.pop_front();
          in_tuser  <= item.req;
          in_tdata  <= {1'b0, item.pos, item.key};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        rcv_count++;
        if (rcv_count == 40 || rcv_count == 1300)
          stall_left = LONG_HOLD;
        else
          stall_left = ((rcv_count / 100) % 4 == 1) ? 0 : $urandom_range(0, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int made;
    int phase_no;
    int phase;
    int len;
    int pick;
    int j;
    okle_pkg::req_t req;

    // empty list
    add_req(okle_pkg::REQ_RM_HEAD, 32'sd1, 7'd0);
    add_req(okle_pkg::REQ_RM_TAIL, 32'sd1, 7'd0);
    add_req(okle_pkg::REQ_RM_KEY, 32'sd1, 7'd0);
    add_req(okle_pkg::REQ_FIND, 32'sd1, 7'd0);
    add_req(okle_pkg::REQ_READ, 32'sd1, 7'd1);
    // drop the only entry
    add_req(okle_pkg::REQ_INS_TAIL, 32'sd7, 7'd0);
    add_req(okle_pkg::REQ_RM_KEY, 32'sd7, 7'd0);
    add_req(okle_pkg::REQ_INS_HEAD, 32'sd3, 7'd0);
    add_req(okle_pkg::REQ_RM_HEAD, 32'sd0, 7'd0);
    add_req(okle_pkg::REQ_INS_ORD, 32'sd5, 7'd0);
    add_req(okle_pkg::REQ_RM_TAIL, 32'sd0, 7'd0);
    // build a list with extremes and duplicates
    add_req(okle_pkg::REQ_INS_ORD, 32'sd5, 7'd0);
    add_req(okle_pkg::REQ_INS_HEAD, 32'sh8000_0000, 7'd0);
    add_req(okle_pkg::REQ_INS_TAIL, 32'sh7fff_ffff, 7'd0);
    add_req(okle_pkg::REQ_INS_ORD, 32'sd5, 7'd0);
    add_req(okle_pkg::REQ_INS_ORD, 32'sh8000_0000, 7'd0);
    add_req(okle_pkg::REQ_INS_ORD, -32'sd1, 7'd0);
    add_req(okle_pkg::REQ_READ, 32'sd0, 7'd0);
    add_req(okle_pkg::REQ_READ, 32'sd0, 7'd64);
    add_req(okle_pkg::REQ_READ, 32'sd0, 7'd1);
    add_req(okle_pkg::REQ_READ, 32'sd0, 7'd6);
    add_req(okle_pkg::REQ_FIND, 32'sd5, 7'd127);
    add_req(okle_pkg::REQ_FIND, 32'sd1234, 7'd0);
    add_req(okle_pkg::REQ_RM_KEY, 32'sh8000_0000, 7'd0);
    add_req(okle_pkg::REQ_RM_KEY, 32'sd999, 7'd0);

    made = 0;
    phase_no = 0;
    while (made < RANDOM_REQS) begin
      phase = (phase_no == 0) ? 0 : $urandom_range(0, 3);
      len   = (phase_no == 0) ? 90 : $urandom_range(20, 90);
      for (j = 0; j < len; j++) begin
        pick = $urandom_range(0, 9);
        case (phase)
          0: req = (pick < 9) ? okle_pkg::req_t'($urandom_range(0, 2))
                              : okle_pkg::req_t'($urandom_range(3, 7));
          1: req = (pick < 8) ? okle_pkg::req_t'($urandom_range(3, 5))
                              : okle_pkg::req_t'($urandom_range(0, 7));
          2: req = okle_pkg::req_t'($urandom_range(0, 7));
          default: req = (pick < 6) ? okle_pkg::req_t'($urandom_range(6, 7))
                                    : okle_pkg::req_t'($urandom_range(0, 5));
        endcase
        add_req(req, draw_key(), draw_pos(), j == 0 && phase_no % 6 == 0);
        made++;
      end
      phase_no++;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (request_queue.size() > 0 || in_tvalid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (failed)
      $display("Some tests failed");
    else
      $display("All tests passed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/okle_pkg.sv
rtl/core/okle_cmp.sv
rtl/core/okle_store.sv
rtl/core/okle_seq.sv
rtl/core/ordered_key_list_engine.sv
rtl/core/okle_chk.sv
sim/testbench.sv
